// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Field widths, action and status codes, and the controller state type
// shared by the deque interfaces and modules.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int ACTION_W       = 3;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int ELEMENT_W      = 32;
    localparam int OCC_W          = 5;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_DUMP_FWD   = 3'd4,
        ACT_DUMP_BWD   = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

endpackage

// File: rtl/bdq_if.sv
// ----------------------------------------------------------------------------
// Bounded deque channels
// Valid/ready channels for action transactions and result transactions.
// ----------------------------------------------------------------------------
interface bdq_in_if
    import bdq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface bdq_out_if
    import bdq_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic signed [ELEMENT_W-1:0] element;
    logic                        final_flag;
    logic [OCC_W-1:0]            occupancy;

    modport source (output valid, output status, output element, output final_flag,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input element, input final_flag,
                    input occupancy, output ready);
endinterface

// File: rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// Bounded deque element memory
// Ring store with one write port and one read port; read data is registered
// and holds its value while no read is issued.
// ----------------------------------------------------------------------------
module bdq_ram
    import bdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int IW        = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [IW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [IW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded deque controller
// Holds head and count, decodes actions, writes pushes to the memory, streams
// dumps out of it, and owns the result register.
// ----------------------------------------------------------------------------
module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int IW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bdq_in_if.sink                i_in,
    bdq_out_if.source             o_out,
    output logic                  o_we,
    output logic [IW-1:0]         o_waddr,
    output logic [DATA_WIDTH-1:0] o_wdata,
    output logic                  o_re,
    output logic [IW-1:0]         o_raddr,
    input  logic [DATA_WIDTH-1:0] i_rdata
);

    localparam int SW = CW + 1;

    t_state               r_state, n_state;
    logic [IW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_rd_addr, n_rd_addr;
    logic [CW-1:0]        r_left, n_left;
    logic                 r_bwd, n_bwd;
    logic                 r_rd_pend, n_rd_pend;
    logic                 r_rd_last, n_rd_last;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [ELEMENT_W-1:0] r_out_element, n_out_element;
    logic                 r_out_final, n_out_final;
    logic [OCC_W-1:0]     r_out_occ, n_out_occ;

    t_action              act;
    logic                 out_free;
    logic                 accept;
    logic                 move;
    logic                 rd_issue;
    logic                 full;
    logic                 empty;
    logic                 is_dump;
    logic                 start_dump;
    logic                 res_load;
    t_status              res_status;
    logic [SW-1:0]        wr_sum;
    logic [SW-1:0]        bk_sum;
    logic [IW-1:0]        wr_idx;
    logic [IW-1:0]        bk_idx;
    logic [IW-1:0]        head_inc;
    logic [IW-1:0]        head_dec;
    logic [IW-1:0]        addr_inc;
    logic [IW-1:0]        addr_dec;
    logic [CW+OCC_W-1:0]  occ_ext;
    logic [DATA_WIDTH+VALUE_W-1:0]   wdata_ext;
    logic [DATA_WIDTH+ELEMENT_W-1:0] rdata_ext;

    assign act      = t_action'(i_in.action);
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign out_free = !r_out_valid || o_out.ready;
    assign accept   = i_in.valid && i_in.ready;
    assign move     = r_rd_pend && out_free;

    assign wr_sum   = SW'(r_head) + SW'(r_count);
    assign bk_sum   = SW'(r_head) + SW'(r_count) - SW'(1);
    assign wr_idx   = (wr_sum >= SW'(DEPTH)) ? IW'(wr_sum - SW'(DEPTH)) : IW'(wr_sum);
    assign bk_idx   = (bk_sum >= SW'(DEPTH)) ? IW'(bk_sum - SW'(DEPTH)) : IW'(bk_sum);
    assign head_inc = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + IW'(1);
    assign head_dec = (r_head == '0) ? IW'(DEPTH - 1) : r_head - IW'(1);
    assign addr_inc = (r_rd_addr == IW'(DEPTH - 1)) ? '0 : r_rd_addr + IW'(1);
    assign addr_dec = (r_rd_addr == '0) ? IW'(DEPTH - 1) : r_rd_addr - IW'(1);

    assign wdata_ext = {{DATA_WIDTH{1'b0}}, i_in.value};
    assign rdata_ext = {{ELEMENT_W{i_rdata[DATA_WIDTH-1]}}, i_rdata};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start_dump) begin
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (move && r_rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        rd_issue   = 1'b0;
        unique case (r_state)
            S_IDLE: i_in.ready = out_free;
            S_DUMP: rd_issue = (r_left != '0) && (!r_rd_pend || move);
            default: i_in.ready = 1'b0;
        endcase
    end

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        o_we       = 1'b0;
        o_waddr    = wr_idx;
        res_status = ST_OK;
        is_dump    = 1'b0;
        unique case (act) inside
            ACT_PUSH_BACK: begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    o_we    = accept;
                    n_count = r_count + CW'(1);
                end
            end
            ACT_PUSH_FRONT: begin
                o_waddr = head_dec;
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    o_we    = accept;
                    n_head  = head_dec;
                    n_count = r_count + CW'(1);
                end
            end
            ACT_POP_BACK: begin
                if (empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            ACT_POP_FRONT: begin
                if (empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - CW'(1);
                end
            end
            ACT_DUMP_FWD, ACT_DUMP_BWD: begin
                is_dump = 1'b1;
                if (empty) begin
                    res_status = ST_EMPTY;
                end
            end
            default: res_status = ST_OK;
        endcase
    end

    assign o_wdata    = wdata_ext[DATA_WIDTH-1:0];
    assign start_dump = accept && is_dump && !empty;
    assign res_load   = accept && !(is_dump && !empty);
    assign occ_ext    = CW'(accept ? n_count : r_count) + (CW + OCC_W)'(0);

    assign o_re    = rd_issue;
    assign o_raddr = r_rd_addr;

    always_comb begin
        n_bwd     = r_bwd;
        n_rd_addr = r_rd_addr;
        n_left    = r_left;
        n_rd_last = r_rd_last;
        n_rd_pend = r_rd_pend;
        if (start_dump) begin
            n_bwd     = (act == ACT_DUMP_BWD);
            n_rd_addr = (act == ACT_DUMP_BWD) ? bk_idx : r_head;
            n_left    = r_count;
        end else if (rd_issue) begin
            n_rd_addr = r_bwd ? addr_dec : addr_inc;
            n_left    = r_left - CW'(1);
            n_rd_last = (r_left == CW'(1));
        end
        if (rd_issue) begin
            n_rd_pend = 1'b1;
        end else if (move) begin
            n_rd_pend = 1'b0;
        end
    end

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_element = r_out_element;
        n_out_final   = r_out_final;
        n_out_occ     = r_out_occ;
        if (move) begin
            n_out_valid   = 1'b1;
            n_out_status  = ST_OK;
            n_out_element = rdata_ext[ELEMENT_W-1:0];
            n_out_final   = r_rd_last;
            n_out_occ     = occ_ext[OCC_W-1:0];
        end else if (res_load) begin
            n_out_valid   = 1'b1;
            n_out_status  = res_status;
            n_out_element = '0;
            n_out_final   = 1'b1;
            n_out_occ     = occ_ext[OCC_W-1:0];
        end else if (o_out.ready) begin
            n_out_valid   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= accept ? n_head : r_head;
            r_count     <= accept ? n_count : r_count;
            r_left      <= n_left;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bwd         <= n_bwd;
        r_rd_addr     <= n_rd_addr;
        r_rd_last     <= n_rd_last;
        r_out_status  <= n_out_status;
        r_out_element <= n_out_element;
        r_out_final   <= n_out_final;
        r_out_occ     <= n_out_occ;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.element    = r_out_element;
    assign o_out.final_flag = r_out_final;
    assign o_out.occupancy  = r_out_occ;

endmodule

// File: rtl/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// Bounded double-ended queue
// Ring-buffer deque of DATA_WIDTH-bit elements with push, pop and dump actions.
//
//   Channel  Direction  Payload                                  Transaction
//   i_in     sink       action, value                            one action
//   o_out    source     status, element, final_flag, occupancy   one result
//
// Push, pop and unknown actions each have their result registered and valid on
// the next cycle, and a new action follows at once while the result register is free.
// A dump of n elements, once taken, holds the input until its last element
// moves to the result register: one memory read is issued per cycle through the
// single read port while the result register is free, and read data is registered.
// A stalled result register stops both new actions and dump reads.
// Reset clears head, count and control; the memory is not cleared.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
    import bdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdq_in_if.sink    i_in,
    bdq_out_if.source o_out
);

    localparam int IW = $clog2(DEPTH);

    logic                  we;
    logic [IW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] rdata;

    bdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    bdq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

`ifndef SYNTHESIS
    a_ready_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!o_out.valid || o_out.ready))
        else $error("Action taken while the result register is blocked.");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.action != ACT_DUMP_FWD
         && i_in.action != ACT_DUMP_BWD) |=> (o_out.valid && o_out.final_flag))
        else $error("Single-result action did not produce a final result.");

    a_dump_in_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.final_flag) |-> (o_out.status == ST_OK && !i_in.ready))
        else $error("Non-final result outside of a dump.");
`endif

endmodule
